// ----- rtl/core/dlfb_pkg.sv -----
`timescale 1ns / 1ps
package dlfb_pkg;

  localparam int DEF_MAX_IN    = 64;
  localparam int DEF_MAX_OUT   = 16;
  localparam int DEF_MAX_BATCH = 4;

  localparam int ACC_W  = 64;
  localparam int TERM_W = 48;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] ACT_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] ACT_LOAD_BIAS   = 2'd1;
  localparam logic [1:0] ACT_FORWARD     = 2'd2;
  localparam logic [1:0] ACT_BACKWARD    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE   = 3'd4;

  localparam logic KIND_FORWARD  = 1'b0;
  localparam logic KIND_GRADIENT = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         index;
    logic signed [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               result_kind;
    logic [5:0]         position;
    logic [1:0]         sample_number;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_init;
    logic acc_sub;
  } mac_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -ACC_W'(64'sh8000_0000);
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return 32'(v);
  endfunction

endpackage

// ----- rtl/core/dlfb_ram.sv -----
`timescale 1ns / 1ps
module dlfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/dlfb_mac.sv -----
`timescale 1ns / 1ps
module dlfb_mac (
  input  logic                                clk,
  input  dlfb_pkg::mac_ctrl_t                 ctrl,
  input  logic signed [31:0]                  op_a,
  input  logic signed [31:0]                  op_b,
  input  logic signed [31:0]                  base,
  output logic signed [dlfb_pkg::ACC_W-1:0]   acc
);

  logic signed [63:0]                  prod;
  logic signed [dlfb_pkg::TERM_W-1:0]  term;
  logic signed [dlfb_pkg::ACC_W-1:0]   term_x;
  logic signed [dlfb_pkg::ACC_W-1:0]   start;

  assign prod   = op_a * op_b;
  assign term_x = dlfb_pkg::ACC_W'(term);
  assign start  = ctrl.acc_init ? dlfb_pkg::ACC_W'(base) : acc;

  // arithmetic shift floors the product back to Q16.16
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      term <= dlfb_pkg::TERM_W'(prod >>> 16);
    end
    if (ctrl.acc_en) begin
      acc <= ctrl.acc_sub ? start - term_x : start + term_x;
    end
  end

endmodule

// ----- rtl/core/dense_layer_forward_backward_core.sv -----
`timescale 1ns / 1ps
// Dense layer with forward pass, backward pass and SGD update in signed Q16.16.
// A load transfer writes one weight or bias word. A forward or backward element
// is only stored unless it completes a sample; then the block stalls its input
// while one shared multiply-accumulate unit walks the weights, each product term
// passing through memory read, multiply, accumulate, and write back or emit. A
// forward sample walks in*out terms; a backward sample walks out*in terms for
// weight gradients, in*out for input gradients, out for the bias update on the
// first sample when bias is on, and out*in more for the weight update after the
// last sample of a batch. Results leave through an output register, so a
// stalled consumer pauses the sweep only at an emitting term.
module dense_layer_forward_backward_core #(
  parameter int MAX_IN    = dlfb_pkg::DEF_MAX_IN,
  parameter int MAX_OUT   = dlfb_pkg::DEF_MAX_OUT,
  parameter int MAX_BATCH = dlfb_pkg::DEF_MAX_BATCH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  dlfb_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output dlfb_pkg::out_item_t               out_data,
  input  logic                              cfg_write,
  input  logic [dlfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlfb_pkg::CFG_W-1:0]        cfg_data
);

  localparam int WDEPTH = MAX_IN * MAX_OUT;
  localparam int SDEPTH = MAX_BATCH * MAX_IN;
  localparam int WA_W   = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
  localparam int SA_W   = SDEPTH > 1 ? $clog2(SDEPTH) : 1;
  localparam int BI_W   = MAX_OUT > 1 ? $clog2(MAX_OUT) : 1;
  localparam int JI_W   = MAX_IN > 1 ? $clog2(MAX_IN) : 1;
  localparam int BS_W   = MAX_BATCH > 1 ? $clog2(MAX_BATCH) : 1;
  localparam int NI_W   = $clog2(MAX_IN + 1);
  localparam int NO_W   = $clog2(MAX_OUT + 1);
  localparam int NB_W   = $clog2(MAX_BATCH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FWD  = 3'd1;
  localparam logic [2:0] ST_WGR  = 3'd2;
  localparam logic [2:0] ST_IGR  = 3'd3;
  localparam logic [2:0] ST_BUPD = 3'd4;
  localparam logic [2:0] ST_WUPD = 3'd5;

  localparam logic [1:0] PH_READ = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_ACC  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // configuration registers
  logic [6:0]  in_count;
  logic [4:0]  out_count;
  logic [2:0]  batch_count;
  logic        bias_on;
  logic [15:0] step_size;

  logic [NI_W-1:0] ni;
  logic [NO_W-1:0] no;
  logic [NB_W-1:0] nb;

  // sequencer
  logic [2:0]      state;
  logic [1:0]      ph;
  logic [BI_W-1:0] oi;
  logic [JI_W-1:0] ij;
  logic [WA_W-1:0] wa;
  logic [JI_W-1:0] fe;
  logic [BI_W-1:0] be;
  logic [BS_W-1:0] fs;
  logic [BS_W-1:0] bs;

  logic            in_take;
  logic            can_emit;
  logic            emit_now;
  logic            last_i;
  logic            last_j;
  logic [BS_W-1:0] cur_s;
  logic            bias_pass;
  logic            batch_end;

  logic signed [31:0] w_q, wg_q, s_q, b_q, g_q;
  logic signed [31:0] op_a, op_b, base;
  logic signed [dlfb_pkg::ACC_W-1:0] acc;
  logic signed [31:0] res;
  dlfb_pkg::mac_ctrl_t mac_ctrl;

  logic            w_we, b_we, s_we, g_we, wg_we;
  logic [WA_W-1:0] w_waddr;
  logic [BI_W-1:0] b_waddr;
  logic [SA_W-1:0] s_waddr, s_raddr;
  logic [31:0]     w_wdata, b_wdata;

  // clamp counts: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (in_count == 7'd0) begin
      ni = NI_W'(1);
    end else if (32'(in_count) > MAX_IN) begin
      ni = NI_W'(MAX_IN);
    end else begin
      ni = NI_W'(in_count);
    end
    if (out_count == 5'd0) begin
      no = NO_W'(1);
    end else if (32'(out_count) > MAX_OUT) begin
      no = NO_W'(MAX_OUT);
    end else begin
      no = NO_W'(out_count);
    end
    if (batch_count == 3'd0) begin
      nb = NB_W'(1);
    end else if (32'(batch_count) > MAX_BATCH) begin
      nb = NB_W'(MAX_BATCH);
    end else begin
      nb = NB_W'(batch_count);
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign can_emit  = !out_valid || !out_stall;
  assign last_i    = (NO_W'(oi) == no - NO_W'(1));
  assign last_j    = (NI_W'(ij) == ni - NI_W'(1));
  assign cur_s     = (state == ST_FWD) ? fs : bs;
  assign bias_pass = bias_on && (bs == '0);
  assign batch_end = (32'(bs) + 1 >= 32'(nb));
  assign res       = dlfb_pkg::sat32(acc);
  // load the output register at the last term of a forward row or a gradient column
  assign emit_now  = (ph == PH_DONE) && can_emit &&
                     ((state == ST_FWD && last_j) || (state == ST_IGR && last_i));

  // operand routing for the shared unit
  always_comb begin
    op_a = s_q;
    op_b = w_q;
    base = '0;
    mac_ctrl.acc_init = 1'b1;
    mac_ctrl.acc_sub  = 1'b0;
    unique case (state)
      ST_FWD: begin
        op_a = s_q;
        op_b = w_q;
        base = bias_on ? b_q : '0;
        mac_ctrl.acc_init = (ij == '0);
      end
      ST_WGR: begin
        op_a = g_q;
        op_b = s_q;
        base = (bs == '0) ? '0 : wg_q;
      end
      ST_IGR: begin
        op_a = w_q;
        op_b = g_q;
        mac_ctrl.acc_init = (oi == '0);
      end
      ST_BUPD: begin
        op_a = {16'd0, step_size};
        op_b = g_q;
        base = b_q;
        mac_ctrl.acc_sub = 1'b1;
      end
      ST_WUPD: begin
        op_a = {16'd0, step_size};
        op_b = wg_q;
        base = w_q;
        mac_ctrl.acc_sub = 1'b1;
      end
      default: begin
        op_a = s_q;
        op_b = w_q;
      end
    endcase
    mac_ctrl.mul_en = (state != ST_IDLE) && (ph == PH_MUL);
    mac_ctrl.acc_en = (state != ST_IDLE) && (ph == PH_ACC);
  end

  // memory write ports: input transfers in idle, write-backs at the end of a term
  always_comb begin
    w_we    = (in_take && in_data.action == dlfb_pkg::ACT_LOAD_WEIGHT &&
               32'(in_data.index) < WDEPTH) || (state == ST_WUPD && ph == PH_DONE);
    w_waddr = (state == ST_WUPD) ? wa : WA_W'(in_data.index);
    w_wdata = (state == ST_WUPD) ? res : in_data.data_value;
    b_we    = (in_take && in_data.action == dlfb_pkg::ACT_LOAD_BIAS &&
               32'(in_data.index) < MAX_OUT) || (state == ST_BUPD && ph == PH_DONE);
    b_waddr = (state == ST_BUPD) ? oi : BI_W'(in_data.index);
    b_wdata = (state == ST_BUPD) ? res : in_data.data_value;
    s_we    = in_take && in_data.action == dlfb_pkg::ACT_FORWARD;
    s_waddr = SA_W'(32'(fs) * MAX_IN + 32'(fe));
    s_raddr = SA_W'(32'(cur_s) * MAX_IN + 32'(ij));
    g_we    = in_take && in_data.action == dlfb_pkg::ACT_BACKWARD;
    wg_we   = (state == ST_WGR) && (ph == PH_DONE);
  end

  dlfb_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(wa), .rdata(w_q)
  );

  dlfb_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_wgrad (
    .clk(clk), .we(wg_we), .waddr(wa), .wdata(res), .raddr(wa), .rdata(wg_q)
  );

  dlfb_ram #(.WIDTH(32), .DEPTH(SDEPTH)) u_saved (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_data.data_value),
    .raddr(s_raddr), .rdata(s_q)
  );

  dlfb_ram #(.WIDTH(32), .DEPTH(MAX_OUT)) u_bias (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(oi), .rdata(b_q)
  );

  dlfb_ram #(.WIDTH(32), .DEPTH(MAX_OUT)) u_gbuf (
    .clk(clk), .we(g_we), .waddr(be), .wdata(in_data.data_value), .raddr(oi),
    .rdata(g_q)
  );

  dlfb_mac u_mac (
    .clk(clk), .ctrl(mac_ctrl), .op_a(op_a), .op_b(op_b), .base(base), .acc(acc)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      in_count    <= 7'd64;
      out_count   <= 5'd10;
      batch_count <= 3'd2;
      bias_on     <= 1'b1;
      step_size   <= 16'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dlfb_pkg::REG_IN_COUNT:    in_count    <= cfg_data[6:0];
        dlfb_pkg::REG_OUT_COUNT:   out_count   <= cfg_data[4:0];
        dlfb_pkg::REG_BATCH_COUNT: batch_count <= cfg_data[2:0];
        dlfb_pkg::REG_BIAS_ON:     bias_on     <= cfg_data[0];
        dlfb_pkg::REG_STEP_SIZE:   step_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register: payload needs no reset
  always_ff @(posedge clk) begin
    if (emit_now) begin
      out_data.result_value  <= res;
      out_data.result_kind   <= (state == ST_FWD) ? dlfb_pkg::KIND_FORWARD
                                                  : dlfb_pkg::KIND_GRADIENT;
      out_data.position      <= (state == ST_FWD) ? 6'(oi) : 6'(ij);
      out_data.sample_number <= 2'(cur_s);
      out_data.last_of_run   <= (state == ST_FWD) ? last_i : last_j;
    end
  end

  // hold valid until the transfer, raise it again on a new result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit_now || (out_valid && out_stall);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ph        <= PH_READ;
      oi        <= '0;
      ij        <= '0;
      wa        <= '0;
      fe        <= '0;
      be        <= '0;
      fs        <= '0;
      bs        <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          ph <= PH_READ;
          oi <= '0;
          ij <= '0;
          wa <= '0;
          if (in_take && in_data.action == dlfb_pkg::ACT_FORWARD) begin
            // sample complete once the element count reaches the clamped input count
            if (32'(fe) + 1 >= 32'(ni)) begin
              fe    <= '0;
              state <= ST_FWD;
            end else begin
              fe <= fe + JI_W'(1);
            end
          end else if (in_take && in_data.action == dlfb_pkg::ACT_BACKWARD) begin
            if (32'(be) + 1 >= 32'(no)) begin
              be    <= '0;
              state <= ST_WGR;
            end else begin
              be <= be + BI_W'(1);
            end
          end
        end
        default: begin
          priority case (ph)
            PH_READ: ph <= PH_MUL;
            PH_MUL:  ph <= PH_ACC;
            PH_ACC:  ph <= PH_DONE;
            default: begin
              unique case (state)
                ST_FWD: begin
                  if (!last_j) begin
                    ij <= ij + JI_W'(1);
                    wa <= wa + WA_W'(1);
                    ph <= PH_READ;
                  end else if (can_emit) begin
                    ph        <= PH_READ;
                    ij        <= '0;
                    wa        <= wa + WA_W'(1);
                    oi        <= oi + BI_W'(1);
                    if (last_i) begin
                      state <= ST_IDLE;
                      fs    <= (32'(fs) + 1 >= 32'(nb)) ? '0 : fs + BS_W'(1);
                    end
                  end
                end
                ST_WGR, ST_WUPD: begin
                  ph <= PH_READ;
                  if (!last_j) begin
                    ij <= ij + JI_W'(1);
                    wa <= wa + WA_W'(1);
                  end else if (!last_i) begin
                    ij <= '0;
                    oi <= oi + BI_W'(1);
                    wa <= wa + WA_W'(1);
                  end else begin
                    ij    <= '0;
                    oi    <= '0;
                    wa    <= '0;
                    state <= (state == ST_WGR) ? ST_IGR : ST_IDLE;
                  end
                end
                ST_IGR: begin
                  // inner walk over outputs steps the weight address by the clamped input count
                  if (!last_i) begin
                    oi <= oi + BI_W'(1);
                    wa <= wa + WA_W'(ni);
                    ph <= PH_READ;
                  end else if (can_emit) begin
                    ph        <= PH_READ;
                    oi        <= '0;
                    if (!last_j) begin
                      ij <= ij + JI_W'(1);
                      wa <= WA_W'(32'(ij) + 1);
                    end else begin
                      ij <= '0;
                      wa <= '0;
                      if (bias_pass) begin
                        state <= ST_BUPD;
                      end else if (batch_end) begin
                        bs    <= '0;
                        state <= ST_WUPD;
                      end else begin
                        bs    <= bs + BS_W'(1);
                        state <= ST_IDLE;
                      end
                    end
                  end
                end
                ST_BUPD: begin
                  ph <= PH_READ;
                  if (!last_i) begin
                    oi <= oi + BI_W'(1);
                  end else begin
                    oi <= '0;
                    if (batch_end) begin
                      bs    <= '0;
                      state <= ST_WUPD;
                    end else begin
                      bs    <= bs + BS_W'(1);
                      state <= ST_IDLE;
                    end
                  end
                end
                default: state <= ST_IDLE;
              endcase
            end
          endcase
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_ITEMS = 175;

  // Directed stimulus row; want is only meaningful where typed is set
  typedef struct {
    logic [1:0]  act;
    logic [9:0]  idx;
    logic [31:0] val;
    bit          typed;
    logic [31:0] want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dlfb_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dlfb_pkg::out_item_t out_data;
  logic                           cfg_write = 1'b0;
  logic [dlfb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dlfb_pkg::CFG_W-1:0]     cfg_data = '0;

  dense_layer_forward_backward_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the layer: stores, counters and registers
  int w_mem [1024];
  int b_mem [16];
  int x_mem [256];
  int g_mem [1024];
  int dy_mem [16];
  int unsigned fwd_smp, fwd_elt, bwd_smp, bwd_elt;
  int unsigned r_in, r_out, r_batch, r_bias, r_lr;

  dlfb_pkg::out_item_t layer_q[$];

  int errors;
  int n_items;
  int n_results;
  int rnd_items;
  int tx_pct;
  int rx_pct;
  bit hold_trig = 1'b0;
  bit hold_seen;
  int hold_left;

  task automatic report_mismatch(input string what);
    if (errors < 40) $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int clamp_n(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Exact product, then floor shift by 16
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic int q_sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  task automatic add_result(input int v, input logic k, input int unsigned pos,
                            input int unsigned smp, input bit last);
    dlfb_pkg::out_item_t r;
    r.result_value  = v;
    r.result_kind   = k;
    r.position      = pos[5:0];
    r.sample_number = smp[1:0];
    r.last_of_run   = last;
    layer_q.push_back(r);
  endtask

  // Advance the shadow layer by one accepted transfer
  task automatic layer_predict(input dlfb_pkg::in_item_t it);
    int unsigned ni, no, nb, s, i, j, w;
    int d;
    longint acc;
    ni = clamp_n(r_in, 64);
    no = clamp_n(r_out, 16);
    nb = clamp_n(r_batch, 4);
    d = it.data_value;
    case (it.action)
      dlfb_pkg::ACT_LOAD_WEIGHT: w_mem[it.index] = d;
      dlfb_pkg::ACT_LOAD_BIAS: if (it.index < 16) b_mem[it.index] = d;
      dlfb_pkg::ACT_FORWARD: begin
        s = fwd_smp % 4;
        x_mem[s * 64 + fwd_elt % 64] = d;
        fwd_elt++;
        if (fwd_elt >= ni) begin
          fwd_elt = 0;
          for (i = 0; i < no; i++) begin
            acc = r_bias ? longint'(b_mem[i]) : 0;
            for (j = 0; j < ni; j++) acc += q_mul(x_mem[s * 64 + j], w_mem[i * ni + j]);
            add_result(q_sat(acc), dlfb_pkg::KIND_FORWARD, i, s, i + 1 == no);
          end
          fwd_smp++;
          if (fwd_smp >= nb) fwd_smp = 0;
        end
      end
      default: begin
        s = bwd_smp % 4;
        dy_mem[bwd_elt % 16] = d;
        bwd_elt++;
        if (bwd_elt >= no) begin
          bwd_elt = 0;
          for (i = 0; i < no; i++) begin
            for (j = 0; j < ni; j++) begin
              w = i * ni + j;
              if (s == 0) g_mem[w] = q_sat(q_mul(dy_mem[i], x_mem[s * 64 + j]));
              else g_mem[w] = q_sat(longint'(g_mem[w]) + q_mul(dy_mem[i], x_mem[s * 64 + j]));
            end
          end
          for (j = 0; j < ni; j++) begin
            acc = 0;
            for (i = 0; i < no; i++) acc += q_mul(w_mem[i * ni + j], dy_mem[i]);
            add_result(q_sat(acc), dlfb_pkg::KIND_GRADIENT, j, s, j + 1 == ni);
          end
          if (r_bias && s == 0) begin
            for (i = 0; i < no; i++) b_mem[i] = q_sat(longint'(b_mem[i]) - q_mul(r_lr, dy_mem[i]));
          end
          bwd_smp++;
          if (bwd_smp >= nb) begin
            bwd_smp = 0;
            for (i = 0; i < no * ni; i++)
              w_mem[i] = q_sat(longint'(w_mem[i]) - q_mul(r_lr, g_mem[i]));
          end
        end
      end
    endcase
  endtask

  // Offer one transfer, idling first at the current rate, and hold until taken
  task automatic push_item(input logic [1:0] a, input logic [9:0] ix, input logic [31:0] v);
    dlfb_pkg::in_item_t it;
    it.action = a;
    it.index = ix;
    it.data_value = v;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    layer_predict(it);
    n_items++;
  endtask

  // Drop valid, wait for every expected result, then let any sweep finish
  task automatic settle();
    int unsigned extra;
    in_valid <= 1'b0;
    @(posedge clk);
    while (layer_q.size() != 0) @(posedge clk);
    extra = 8 * clamp_n(r_in, 64) * clamp_n(r_out, 16) + 64;
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_regs(input int unsigned ni, input int unsigned no, input int unsigned nb,
                            input int unsigned ub, input int unsigned lr);
    int unsigned vals [5];
    logic [dlfb_pkg::CFG_IDX_W-1:0] idxs [5];
    vals = '{ni, no, nb, ub, lr};
    idxs = '{dlfb_pkg::REG_IN_COUNT, dlfb_pkg::REG_OUT_COUNT, dlfb_pkg::REG_BATCH_COUNT,
             dlfb_pkg::REG_BIAS_ON, dlfb_pkg::REG_STEP_SIZE};
    for (int k = 0; k < 5; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data <= vals[k][dlfb_pkg::CFG_W-1:0];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    r_in = vals[0] & 32'h7F;
    r_out = vals[1] & 32'h1F;
    r_batch = vals[2] & 32'h7;
    r_bias = vals[3] & 32'h1;
    r_lr = vals[4] & 32'hFFFF;
  endtask

  function automatic logic [31:0] rand_q();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($urandom_range(0, 524287)) - 32'd262144;
  endfunction

  task automatic pick_mode();
    case ($urandom_range(0, 3))
      0: begin tx_pct = 0;  rx_pct = 0;  end
      1: begin tx_pct = 70; rx_pct = 0;  end
      2: begin tx_pct = 0;  rx_pct = 70; end
      default: begin tx_pct = 15; rx_pct = 15; end
    endcase
  endtask

  // Receiver: check each accepted transfer, drive stall
  always @(posedge clk) begin
    dlfb_pkg::out_item_t e;
    if (!rst) begin
      if (out_valid === 1'b1 && !out_stall) begin
        n_results++;
        if (layer_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          e = layer_q.pop_front();
          if (out_data.result_value !== e.result_value)
            report_mismatch($sformatf("value %h want %h", out_data.result_value, e.result_value));
          if (out_data.result_kind !== e.result_kind)
            report_mismatch($sformatf("kind %b want %b", out_data.result_kind, e.result_kind));
          if (out_data.position !== e.position)
            report_mismatch($sformatf("position %0d want %0d", out_data.position, e.position));
          if (out_data.sample_number !== e.sample_number)
            report_mismatch($sformatf("sample %0d want %0d", out_data.sample_number,
                                      e.sample_number));
          if (out_data.last_of_run !== e.last_of_run)
            report_mismatch($sformatf("last %b want %b", out_data.last_of_run, e.last_of_run));
        end
      end
      // a long hold-off is counted here, apart from the sender
      if (hold_trig != hold_seen) begin
        hold_seen = hold_trig;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_pct);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : main
    stim_row_t rows [21];
    int unsigned ni, no, nb, phase, nbat;
    errors = 0;
    n_items = 0;
    n_results = 0;
    rnd_items = 0;
    tx_pct = 0;
    rx_pct = 0;
    hold_seen = 1'b0;
    hold_left = 0;
    fwd_smp = 0; fwd_elt = 0; bwd_smp = 0; bwd_elt = 0;
    r_in = 64; r_out = 10; r_batch = 2; r_bias = 1; r_lr = 0;
    foreach (w_mem[k]) begin w_mem[k] = 0; g_mem[k] = 0; end
    foreach (x_mem[k]) x_mem[k] = 0;
    foreach (b_mem[k]) begin b_mem[k] = 0; dy_mem[k] = 0; end

    rows = '{
      '{dlfb_pkg::ACT_LOAD_WEIGHT, 10'd0,    32'h0001_0000, 0, 32'h0},
      '{dlfb_pkg::ACT_LOAD_BIAS,   10'd0,    32'h7FFF_FFFF, 0, 32'h0},
      '{dlfb_pkg::ACT_LOAD_BIAS,   10'd16,   32'h1234_5678, 0, 32'h0},   // bias index too big
      '{dlfb_pkg::ACT_LOAD_BIAS,   10'd1023, 32'hFFFF_FFFF, 0, 32'h0},
      '{dlfb_pkg::ACT_LOAD_WEIGHT, 10'd1023, 32'hAAAA_5555, 0, 32'h0},
      '{dlfb_pkg::ACT_FORWARD,     10'd0,    32'h0003_0000, 1, 32'h0003_0000},
      '{dlfb_pkg::ACT_FORWARD,     10'd1023, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF},
      '{dlfb_pkg::ACT_FORWARD,     10'h155,  32'h8000_0000, 1, 32'h8000_0000},
      '{dlfb_pkg::ACT_LOAD_WEIGHT, 10'd0,    32'h7FFF_FFFF, 0, 32'h0},
      '{dlfb_pkg::ACT_FORWARD,     10'h2AA,  32'h7FFF_FFFF, 1, 32'h7FFF_FFFF},  // positive sat
      '{dlfb_pkg::ACT_FORWARD,     10'd0,    32'h8000_0000, 1, 32'h8000_0000},  // negative sat
      '{dlfb_pkg::ACT_LOAD_WEIGHT, 10'd0,    32'hFFFF_FFFF, 0, 32'h0},
      '{dlfb_pkg::ACT_FORWARD,     10'd0,    32'h0000_0001, 1, 32'hFFFF_FFFF},  // floor rounding
      '{dlfb_pkg::ACT_BACKWARD,    10'd0,    32'h0001_0000, 1, 32'hFFFF_FFFF},
      '{dlfb_pkg::ACT_BACKWARD,    10'd1023, 32'h7FFF_FFFF, 0, 32'h0},
      '{dlfb_pkg::ACT_BACKWARD,    10'd0,    32'h8000_0000, 0, 32'h0},
      '{dlfb_pkg::ACT_FORWARD,     10'd0,    32'hDEAD_BEEF, 0, 32'h0},
      '{dlfb_pkg::ACT_LOAD_WEIGHT, 10'd0,    32'h0002_0000, 0, 32'h0},
      '{dlfb_pkg::ACT_FORWARD,     10'd0,    32'h7FFF_0000, 0, 32'h0},
      '{dlfb_pkg::ACT_LOAD_WEIGHT, 10'd0,    32'h5555_AAAA, 0, 32'h0},
      '{dlfb_pkg::ACT_BACKWARD,    10'd0,    32'h0000_1234, 0, 32'h0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one-by-one layer, no bias, no learning
    write_regs(1, 1, 1, 0, 0);
    foreach (rows[r]) begin
      push_item(rows[r].act, rows[r].idx, rows[r].val);
      if (rows[r].typed) layer_q[layer_q.size() - 1].result_value = rows[r].want;
    end
    settle();

    // Write every entry the random phases can reach: weights and biases of a
    // six by four layer, all four input slots and a full batch of four backward
    // samples; a raw batch count of seven acts as four
    write_regs(6, 4, 7, 1, 65535);
    for (int k = 0; k < 24; k++) push_item(dlfb_pkg::ACT_LOAD_WEIGHT, 10'(k), rand_q());
    for (int k = 0; k < 4; k++) push_item(dlfb_pkg::ACT_LOAD_BIAS, 10'(k), rand_q());
    pick_mode();
    for (int k = 0; k < 24; k++) push_item(dlfb_pkg::ACT_FORWARD, 10'($urandom), rand_q());
    for (int k = 0; k < 16; k++) push_item(dlfb_pkg::ACT_BACKWARD, 10'($urandom), rand_q());
    settle();

    // Random phases of mostly well-formed batches
    phase = 0;
    while (rnd_items < RANDOM_ITEMS) begin
      settle();
      ni = $urandom_range(0, 6);
      no = $urandom_range(0, 4);
      nb = $urandom_range(0, 7);
      case ($urandom_range(0, 3))
        0: write_regs(ni, no, nb, $urandom_range(0, 1), 0);
        1: write_regs(ni, no, nb, $urandom_range(0, 1), 65535);
        default: write_regs(ni, no, nb, $urandom_range(0, 1), $urandom_range(0, 65535));
      endcase
      ni = clamp_n(r_in, 64);
      no = clamp_n(r_out, 16);
      nb = clamp_n(r_batch, 4);
      nbat = $urandom_range(1, 2);
      pick_mode();
      if (phase == 2) begin
        // fill the block behind a long receiver hold-off while the sender goes on
        tx_pct = 0;
        hold_trig <= ~hold_trig;
      end
      for (int b = 0; b < nbat; b++) begin
        for (int s = 0; s < nb; s++) begin
          for (int e = 0; e < ni; e++) begin
            push_item(dlfb_pkg::ACT_FORWARD, 10'($urandom), rand_q());
            rnd_items++;
          end
          if ($urandom_range(0, 3) == 0) pick_mode();
        end
        for (int s = 0; s < nb; s++) begin
          for (int e = 0; e < no; e++) begin
            push_item(dlfb_pkg::ACT_BACKWARD, 10'($urandom), rand_q());
            rnd_items++;
          end
          if ($urandom_range(0, 3) == 0) pick_mode();
        end
        if ($urandom_range(0, 7) == 0) begin
          push_item(dlfb_pkg::ACT_LOAD_WEIGHT, 10'($urandom), rand_q());
          push_item(dlfb_pkg::ACT_LOAD_BIAS, 10'($urandom_range(0, 31)), rand_q());
        end
        if ($urandom_range(0, 9) == 0) begin
          // stray elements knock the counters out of step
          repeat ($urandom_range(1, 3)) begin
            push_item($urandom_range(0, 1) ? dlfb_pkg::ACT_FORWARD : dlfb_pkg::ACT_BACKWARD,
                      10'($urandom), rand_q());
            rnd_items++;
          end
        end
      end
      phase++;
    end
    settle();

    if (layer_q.size() != 0) report_mismatch("expected results left over");
    $display("covered %0d transfers in, %0d results checked over %0d random phases",
             n_items, n_results, phase);
    $display("with loads, saturation, floor rounding, count clamping and SGD updates");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/dlfb_pkg.sv
rtl/core/dlfb_ram.sv
rtl/core/dlfb_mac.sv
rtl/core/dense_layer_forward_backward_core.sv
tb/sv/testbench.sv
